### rtl/core/lbmb_pkg.sv
// ----------------------------------------------------------------------------
// lbmb_pkg
// Shared types, codes and defaults for the linked-block multireader buffer.
// ----------------------------------------------------------------------------
package lbmb_pkg;

	// field widths fixed by the interface
	localparam int CFG_W   = 3;
	localparam int OP_W    = 2;
	localparam int BYTE_W  = 8;
	localparam int RID_W   = 2;
	localparam int STS_W   = 2;
	localparam int CNT_W   = 16;
	localparam int OFS_W   = 16;

	// parameter defaults
	localparam int NUM_BLOCKS_DEF   = 64;
	localparam int BLOCK_BYTES_DEF  = 1024;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int MAX_READERS_DEF  = 4;

	localparam logic [CFG_W-1:0] NUM_READERS_RST = CFG_W'(2);
	localparam logic [CNT_W-1:0] CNT_MAX         = '1;

	// opcodes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	// result status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
	localparam logic [STS_W-1:0] STS_BAD   = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // latch the input word, issue the store read
		logic commit;   // update state, load the result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic slot_free;
	} dp_sts_t;

endpackage

### rtl/core/lbmb_ram.sv
// ----------------------------------------------------------------------------
// lbmb_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/lbmb_ctrl.sv
// ----------------------------------------------------------------------------
// lbmb_ctrl
// Sequencer: takes one word, waits for the store read, commits when the
// result register has room.
// ----------------------------------------------------------------------------
module lbmb_ctrl
	import lbmb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  dp_sts_t sts,
	output logic    in_stall,
	output dp_cmd_t cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.slot_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_EXEC: begin
				cmd.commit = sts.slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

### rtl/core/lbmb_dpath.sv
// ----------------------------------------------------------------------------
// lbmb_dpath
// Writer and reader positions, free-block counter, byte store and the
// result register.
// ----------------------------------------------------------------------------
module lbmb_dpath
	import lbmb_pkg::*;
#(
	parameter int NUM_BLOCKS   = NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int MAX_READERS  = MAX_READERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic [OP_W-1:0]   opcode,
	input  logic [BYTE_W-1:0] write_data,
	input  logic [RID_W-1:0]  reader_id,
	input  logic              burst_last,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [BYTE_W-1:0] read_data,
	output logic [STS_W-1:0]  status,
	output logic [CNT_W-1:0]  unread_count,
	output logic [OFS_W-1:0]  read_offset,
	output logic              last
);

	localparam int BLK_W       = $clog2(NUM_BLOCKS);
	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int STORE_BYTES = NUM_BLOCKS * BLOCK_BYTES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int IDX_W       = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(BLOCK_BYTES - 1);
	localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HEADER_BYTES);
	localparam logic [BLK_W-1:0] TOP_BLK   = BLK_W'(NUM_BLOCKS - 1);
	localparam logic [BLK_W-1:0] FIRST_BLK = BLK_W'(1);
	localparam logic [BLK_W-1:0] LOW_BLK   = BLK_W'(2);
	localparam logic [BLK_W-1:0] THIRD_BLK = BLK_W'(3);

	function automatic logic [ADDR_W-1:0] addr_of(input logic [BLK_W-1:0] b,
		input logic [POS_W-1:0] p);
		return ADDR_W'(b) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(p);
	endfunction

	// state
	logic [CFG_W-1:0] num_readers_q;
	logic [BLK_W-1:0] wblk_q;
	logic [POS_W-1:0] wpos_q;
	logic [BLK_W-1:0] free_q;
	logic             free_empty_q;
	logic [BLK_W-1:0] rblk_q   [MAX_READERS];
	logic [POS_W-1:0] rpos_q   [MAX_READERS];
	logic [CNT_W-1:0] unread_q [MAX_READERS];

	// latched word
	logic [OP_W-1:0]   op_s1;
	logic [BYTE_W-1:0] wdata_s1;
	logic              blast_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              good_s1;

	// result register
	logic              out_valid_q;
	logic [BYTE_W-1:0] rdata_q;
	logic [STS_W-1:0]  status_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OFS_W-1:0]  ofs_q;
	logic              last_q;

	// ---------------- accept side ----------------
	logic [IDX_W+1:0]  rid_ext;
	logic              in_range;
	logic [IDX_W-1:0]  in_idx;
	logic              in_good;
	logic [ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0] ram_rdata;

	assign rid_ext  = {IDX_W'(0), reader_id};
	assign in_range = 32'(reader_id) < MAX_READERS;
	assign in_idx   = in_range ? rid_ext[IDX_W-1:0] : '0;
	assign in_good  = in_range && ({1'b0, reader_id} < num_readers_q);
	assign rd_addr  = addr_of(rblk_q[in_idx], rpos_q[in_idx]);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1    <= opcode;
			wdata_s1 <= write_data;
			blast_s1 <= burst_last;
			idx_s1   <= in_idx;
			good_s1  <= in_good;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_readers_q <= NUM_READERS_RST;
		end else if (cfg_wr_en) begin
			num_readers_q <= cfg_wr_data;
		end
	end

	// ---------------- commit side ----------------
	logic [BLK_W-1:0]  sel_blk;
	logic [POS_W-1:0]  sel_pos;
	logic [CNT_W-1:0]  sel_cnt;
	logic              w_at_end;
	logic              can_write;
	logic              r_empty;
	logic              lk_valid;
	logic [BLK_W-1:0]  lk_blk;
	logic              wr_ok;
	logic              rd_ok;
	logic [STS_W-1:0]  sts_n;
	logic              last_n;
	logic [BYTE_W-1:0] rdata_n;
	logic [BLK_W-1:0]  rblk_n;
	logic [POS_W-1:0]  rpos_n;
	logic [BLK_W-1:0]  wblk_n;
	logic [POS_W-1:0]  wpos_n;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_dec;
	logic [BLK_W-1:0]  res_blk;
	logic [POS_W-1:0]  res_pos;
	logic [CNT_W-1:0]  res_cnt;
	logic [31:0]       res_ofs;

	assign sel_blk   = rblk_q[idx_s1];
	assign sel_pos   = rpos_q[idx_s1];
	assign sel_cnt   = unread_q[idx_s1];
	assign w_at_end  = (wpos_q == LAST_POS);
	assign can_write = !w_at_end || !free_empty_q;
	assign r_empty   = (sel_blk == wblk_q) && (sel_pos == wpos_q);
	assign cnt_inc   = (sel_cnt == CNT_MAX) ? sel_cnt : sel_cnt + CNT_W'(1);
	assign cnt_dec   = (sel_cnt == '0) ? sel_cnt : sel_cnt - CNT_W'(1);

	// Blocks are popped in descending order and never returned, so the chain
	// is 1 -> top -> top-1 -> ... -> 2 and each link follows from the block
	// number and whether the first pop has happened.
	always_comb begin
		lk_valid = 1'b0;
		lk_blk   = '0;
		if (sel_blk >= THIRD_BLK) begin
			lk_valid = 1'b1;
			lk_blk   = sel_blk - BLK_W'(1);
		end else if (sel_blk == FIRST_BLK && (free_empty_q || free_q != TOP_BLK)) begin
			lk_valid = 1'b1;
			lk_blk   = TOP_BLK;
		end
	end

	always_comb begin
		wr_ok   = 1'b0;
		rd_ok   = 1'b0;
		sts_n   = STS_OK;
		last_n  = blast_s1;
		rdata_n = '0;
		case (op_s1)
			OP_WRITE: begin
				if (can_write) wr_ok = 1'b1;
				else sts_n = STS_FULL;
			end
			OP_READ: begin
				if (!good_s1) begin
					sts_n = STS_BAD;
				end else if (r_empty) begin
					sts_n  = STS_EMPTY;
					last_n = 1'b1;
				end else begin
					rd_ok   = 1'b1;
					rdata_n = ram_rdata;
				end
			end
			default: begin
				if (!good_s1) sts_n = STS_BAD;
			end
		endcase
	end

	always_comb begin
		if (sel_pos == LAST_POS) begin
			// null link: fall back to the writer position
			rblk_n = lk_valid ? lk_blk : wblk_q;
			rpos_n = lk_valid ? HDR_POS : wpos_q;
		end else begin
			rblk_n = sel_blk;
			rpos_n = sel_pos + POS_W'(1);
		end
		if (w_at_end) begin
			wblk_n = free_q;
			wpos_n = HDR_POS;
		end else begin
			wblk_n = wblk_q;
			wpos_n = wpos_q + POS_W'(1);
		end
	end

	always_comb begin
		res_blk = sel_blk;
		res_pos = sel_pos;
		res_cnt = sel_cnt;
		if (wr_ok) begin
			res_cnt = cnt_inc;
		end else if (rd_ok) begin
			res_blk = rblk_n;
			res_pos = rpos_n;
			res_cnt = cnt_dec;
		end
		res_ofs = 32'(addr_of(res_blk, res_pos));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wblk_q       <= FIRST_BLK;
			wpos_q       <= HDR_POS;
			free_q       <= TOP_BLK;
			free_empty_q <= 1'b0;
			for (int i = 0; i < MAX_READERS; i++) begin
				rblk_q[i]   <= FIRST_BLK;
				rpos_q[i]   <= HDR_POS;
				unread_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (wr_ok) begin
				wblk_q <= wblk_n;
				wpos_q <= wpos_n;
				if (w_at_end) begin
					if (free_q == LOW_BLK) free_empty_q <= 1'b1;
					else free_q <= free_q - BLK_W'(1);
				end
				for (int i = 0; i < MAX_READERS; i++) begin
					if (unread_q[i] != CNT_MAX) unread_q[i] <= unread_q[i] + CNT_W'(1);
				end
			end
			if (rd_ok) begin
				rblk_q[idx_s1]   <= rblk_n;
				rpos_q[idx_s1]   <= rpos_n;
				unread_q[idx_s1] <= cnt_dec;
			end
		end
	end

	lbmb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.commit && wr_ok),
		.wr_addr (addr_of(wblk_q, wpos_q)),
		.wr_data (wdata_s1),
		.rd_en   (cmd.accept),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rdata_q  <= rdata_n;
			status_q <= sts_n;
			cnt_q    <= good_s1 ? res_cnt : '0;
			ofs_q    <= good_s1 ? res_ofs[OFS_W-1:0] : '0;
			last_q   <= last_n;
		end
	end

	assign sts.slot_free = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign read_data     = rdata_q;
	assign status        = status_q;
	assign unread_count  = cnt_q;
	assign read_offset   = ofs_q;
	assign last          = last_q;

	// ---------------- checks ----------------
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("commit while result register is occupied");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.commit))
		else $error("accept and commit in one cycle");

	a_wpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wpos_q >= HDR_POS) && (32'(wpos_q) < BLOCK_BYTES))
		else $error("write position outside block payload");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STS_EMPTY) |-> last_q)
		else $error("empty read without last");

	a_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(free_empty_q) |-> ($past(wpos_q) == LAST_POS && $past(free_q) == LOW_BLK))
		else $error("free list drained at wrong point");

endmodule

### rtl/core/linked_block_multireader_buffer_unit.sv
// ----------------------------------------------------------------------------
// linked_block_multireader_buffer_unit
// Byte store of linked fixed-size blocks with one writer and several readers.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command word: write a byte,
// read a byte for a reader, or query a reader. Every word yields exactly one
// result word on the output channel (out_valid / out_stall).
// Timing: a word is taken in one cycle, the byte store read completes in the
// next, and the result is loaded into the output register once that register
// has room. The block takes no new word until the current one is committed.
// The next word is taken while an earlier result still sits in the output
// register; if the receiver keeps stalling, the block holds the finished
// second word internally and stalls the input until the register frees.
// cfg_wr_en / cfg_wr_data write the active reader count; write it only while
// no word is in flight.
// Reset: all positions and counters take their start values at once; the
// byte store itself is not cleared, so no clearing pass is needed and a word
// can be taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module linked_block_multireader_buffer_unit
	import lbmb_pkg::*;
#(
	parameter int NUM_BLOCKS   = NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int MAX_READERS  = MAX_READERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   opcode,
	input  logic [BYTE_W-1:0] write_data,
	input  logic [RID_W-1:0]  reader_id,
	input  logic              burst_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] read_data,
	output logic [STS_W-1:0]  status,
	output logic [CNT_W-1:0]  unread_count,
	output logic [OFS_W-1:0]  read_offset,
	output logic              last
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	lbmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	lbmb_dpath #(
		.NUM_BLOCKS   (NUM_BLOCKS),
		.BLOCK_BYTES  (BLOCK_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_READERS  (MAX_READERS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.opcode       (opcode),
		.write_data   (write_data),
		.reader_id    (reader_id),
		.burst_last   (burst_last),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.read_data    (read_data),
		.status       (status),
		.unread_count (unread_count),
		.read_offset  (read_offset),
		.last         (last)
	);

endmodule
